// ===== rtl/core/imu_gbc_pkg.sv =====
// Shared widths, constants and the lane control struct for the gyro bias calibrator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package imu_gbc_pkg;

    localparam int NUM_AX      = 3;
    localparam int AXIS_W      = 25;
    localparam int OUT_W       = 26;
    localparam int LIM_W       = 24;
    localparam int CFG_W       = 25;
    localparam int CFG_IDX_W   = 2;

    localparam int CAL_COUNT   = 1000;
    localparam int CNT_W       = 10;

    localparam int SQ_W        = 2 * AXIS_W - 1;
    localparam int N2_W        = SQ_W + 1;
    localparam int LSQ_W       = 2 * LIM_W;

    localparam int SUM_W       = 27;
    localparam int OFS_W       = 17;
    localparam int OFS_MAX     = 2 ** (OFS_W - 1) - 1;
    localparam int OFS_NEG_MAG = 2 ** (OFS_W - 1);

    // |bias| = floor((|sum| + C/2) / C), done as multiply by reciprocal plus one fixup
    localparam int MAG_W       = SUM_W;
    localparam int DIV_ROUND   = CAL_COUNT / 2;
    localparam int RECIP_SH    = 30;
    localparam int RCP_W       = 31;
    localparam longint RECIP   = (64'd1 << RECIP_SH) / CAL_COUNT;

    localparam int ITEM_W      = 2 * NUM_AX * OUT_W;
    localparam int IN_TDATA_W  = ((2 * NUM_AX * AXIS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ITEM_W + 7) / 8) * 8;

    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int USED_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Z     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_LIMIT = 2'd3;

    localparam logic [LIM_W-1:0] STILL_LIMIT_RST = 24'd32768;

    typedef struct packed {
        logic clr;
        logic add;
        logic fin;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/imu_gbc_fifo.sv =====
// Output queue of result transactions, FIFO_DEPTH entries in flops.
// Depends on imu_gbc_pkg.
`default_nettype none

module imu_gbc_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [imu_gbc_pkg::ITEM_W-1:0] i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [imu_gbc_pkg::ITEM_W-1:0]     o_data,
    output logic                               o_pop
);
    import imu_gbc_pkg::*;

    logic [ITEM_W-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [USED_W-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (o_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + USED_W'(i_push) - USED_W'(o_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/imu_gbc_lane.sv =====
// One axis lane: gyro square, bias sum and division, accel and gyro offset subtraction.
// Depends on imu_gbc_pkg; driven by imu_gbc_ctrl through t_lane_ctl.
`default_nettype none

module imu_gbc_lane (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic signed [imu_gbc_pkg::AXIS_W-1:0] i_accel,
    input  wire logic signed [imu_gbc_pkg::AXIS_W-1:0] i_gyro,
    input  wire logic signed [imu_gbc_pkg::CFG_W-1:0]  i_accel_ofs,
    input  wire imu_gbc_pkg::t_lane_ctl                i_ctl,
    output logic [imu_gbc_pkg::SQ_W-1:0]              o_sq,
    output logic signed [imu_gbc_pkg::OUT_W-1:0]      o_accel_out,
    output logic signed [imu_gbc_pkg::OUT_W-1:0]      o_gyro_out
);
    import imu_gbc_pkg::*;

    logic signed [AXIS_W-1:0]   r1_acc, r1_gyr, r2_acc, r2_gyr, r3_gyr, r4_gyr;
    logic [SQ_W-1:0]            r1_sq;
    logic signed [OUT_W-1:0]    r3_acc, r4_acc, r5_acc, r5_gyr;

    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic signed [OFS_W-1:0]    r_ofs, n_ofs;
    logic                       r_go1, r_go2, r_go3;
    logic                       r_neg, r_neg2;
    logic [MAG_W-1:0]           r_mag, r_mag2, r_q0;

    logic signed [2*AXIS_W-1:0] gyr_sq;
    logic signed [SUM_W:0]      sum_ext;
    logic [MAG_W-1:0]           mag_abs;
    logic [MAG_W+RCP_W-1:0]     rcp_prod;
    logic [MAG_W+CNT_W-1:0]     q0_prod;
    logic [MAG_W-1:0]           rem;
    logic [MAG_W-1:0]           q_fix;
    logic [OFS_W-1:0]           q_sat;

    assign gyr_sq = i_gyro * i_gyro;
    assign o_sq   = r1_sq;

    // saturating accumulate
    assign sum_ext = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r2_gyr);

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.clr) begin
            n_sum = '0;
        end else if (i_ctl.add) begin
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
                n_sum = {sum_ext[SUM_W], {(SUM_W-1){~sum_ext[SUM_W]}}};
            end else begin
                n_sum = sum_ext[SUM_W-1:0];
            end
        end
    end

    // rounded division by CAL_COUNT, half away from zero
    assign mag_abs  = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);
    assign rcp_prod = {{RCP_W{1'b0}}, r_mag} * (MAG_W+RCP_W)'(RECIP);
    assign q0_prod  = {{CNT_W{1'b0}}, r_q0} * (MAG_W+CNT_W)'(CAL_COUNT);
    assign rem      = r_mag2 - q0_prod[MAG_W-1:0];
    assign q_fix    = (rem >= MAG_W'(CAL_COUNT)) ? r_q0 + 1'b1 : r_q0;

    always_comb begin
        if (r_neg2) begin
            q_sat = (q_fix > MAG_W'(OFS_NEG_MAG)) ? OFS_W'(OFS_NEG_MAG) : q_fix[OFS_W-1:0];
            n_ofs = -$signed(q_sat);
        end else begin
            q_sat = (q_fix > MAG_W'(OFS_MAX)) ? OFS_W'(OFS_MAX) : q_fix[OFS_W-1:0];
            n_ofs = $signed(q_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_ofs <= '0;
            r_go1 <= 1'b0;
            r_go2 <= 1'b0;
            r_go3 <= 1'b0;
        end else begin
            r_sum <= n_sum;
            r_go1 <= i_ctl.fin;
            r_go2 <= r_go1;
            r_go3 <= r_go2;
            if (r_go3) begin
                r_ofs <= n_ofs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_acc <= i_accel;
        r1_gyr <= i_gyro;
        r1_sq  <= SQ_W'($unsigned(gyr_sq));
        r2_acc <= r1_acc;
        r2_gyr <= r1_gyr;
        r3_acc <= OUT_W'(r2_acc) - OUT_W'(i_accel_ofs);
        r3_gyr <= r2_gyr;
        r4_acc <= r3_acc;
        r4_gyr <= r3_gyr;
        r5_acc <= r4_acc;
        r5_gyr <= OUT_W'(r4_gyr) - OUT_W'(r_ofs);
        if (r_go1) begin
            r_mag <= mag_abs + MAG_W'(DIV_ROUND);
            r_neg <= r_sum[SUM_W-1];
        end
        if (r_go2) begin
            r_q0   <= MAG_W'(rcp_prod >> RECIP_SH);
            r_mag2 <= r_mag;
            r_neg2 <= r_neg;
        end
    end

    assign o_accel_out = r5_acc;
    assign o_gyro_out  = r5_gyr;

endmodule

`default_nettype wire

// ===== rtl/core/imu_gbc_ctrl.sv =====
// Merge stage and sequencer: norm from the lane squares, still test, phase and count,
// valid pipeline and queue credit. Depends on imu_gbc_pkg.
`default_nettype none

module imu_gbc_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_pop,
    input  wire logic [imu_gbc_pkg::LIM_W-1:0]  i_still_limit,
    input  wire logic [imu_gbc_pkg::SQ_W-1:0]   i_sq [imu_gbc_pkg::NUM_AX],
    output imu_gbc_pkg::t_lane_ctl              o_ctl,
    output logic                                o_push,
    output logic                                o_ready
);
    import imu_gbc_pkg::*;

    typedef enum logic [1:0] {
        PH_CAL     = 2'd0,
        PH_SWALLOW = 2'd1,
        PH_RUN     = 2'd2
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [USED_W-1:0] r_used;
    logic              r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [N2_W-1:0]   r_n2;
    logic [LSQ_W-1:0]  r_lim_sq;

    logic              still;
    logic              emit;
    logic              drop;
    logic [CNT_W-1:0]  cnt_inc;
    t_lane_ctl         ctl;

    assign still   = (r_n2 <= N2_W'(r_lim_sq));
    assign cnt_inc = r_cnt + 1'b1;

    always_comb begin
        ctl     = '0;
        emit    = 1'b0;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        case (r_phase)
            PH_CAL: begin
                if (r2_v) begin
                    if (!still) begin
                        ctl.clr = 1'b1;
                        n_cnt   = '0;
                    end else begin
                        ctl.add = 1'b1;
                        n_cnt   = cnt_inc;
                        if (cnt_inc == CNT_W'(CAL_COUNT)) begin
                            ctl.fin = 1'b1;
                            n_phase = PH_SWALLOW;
                        end
                    end
                end
            end
            PH_SWALLOW: begin
                if (r2_v) begin
                    n_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                emit = r2_v;
            end
            default: begin
                emit = r2_v;
            end
        endcase
    end

    assign drop    = r2_v && !emit;
    assign o_ctl   = ctl;
    assign o_push  = r5_v;
    assign o_ready = (r_used < USED_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        r_n2     <= N2_W'(i_sq[0]) + N2_W'(i_sq[1]) + N2_W'(i_sq[2]);
        r_lim_sq <= LSQ_W'(i_still_limit) * LSQ_W'(i_still_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CAL;
            r_cnt   <= '0;
            r_used  <= '0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_used  <= r_used + USED_W'(i_accept) - USED_W'(drop) - USED_W'(i_pop);
            r1_v    <= i_accept;
            r2_v    <= r1_v;
            r3_v    <= emit;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/imu_gyro_bias_calibrator.sv =====
// Each result goes through the lane stage registers, then the output queue, before its tvalid.
// Throughput: one sample per cycle; input stalls only while 8 transactions are held.
// No result is given until CAL_COUNT consecutive still samples and the sample after them.
// Bias division trails the last still sample (r_go1 to r_go3), hidden by the swallowed sample.
// Reset (sync, active low) clears phase, sums, biases, queue and accel offsets, presets still limit.
// Top level; depends on imu_gbc_pkg, imu_gbc_lane, imu_gbc_ctrl, imu_gbc_fifo.
`default_nettype none

module imu_gyro_bias_calibrator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // accel_in_x, accel_in_y, accel_in_z, gyro_in_x, gyro_in_y, gyro_in_z
    input  wire logic [imu_gbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // accel_out_x, accel_out_y, accel_out_z, gyro_out_x, gyro_out_y, gyro_out_z
    output logic [imu_gbc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [imu_gbc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [imu_gbc_pkg::CFG_W-1:0]       i_cfg_data
);
    import imu_gbc_pkg::*;

    logic signed [CFG_W-1:0] r_accel_ofs [NUM_AX];
    logic [LIM_W-1:0]        r_still_limit;

    logic                    accept;
    logic                    push;
    logic                    pop;
    t_lane_ctl               lane_ctl;
    logic [SQ_W-1:0]         lane_sq [NUM_AX];
    logic [ITEM_W-1:0]       item;
    logic [ITEM_W-1:0]       q_data;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_ofs[0] <= '0;
            r_accel_ofs[1] <= '0;
            r_accel_ofs[2] <= '0;
            r_still_limit  <= STILL_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACCEL_X:     r_accel_ofs[0] <= i_cfg_data;
                CFG_ACCEL_Y:     r_accel_ofs[1] <= i_cfg_data;
                CFG_ACCEL_Z:     r_accel_ofs[2] <= i_cfg_data;
                CFG_STILL_LIMIT: r_still_limit  <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < NUM_AX; g++) begin : g_lane
        imu_gbc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_accel     (s_axis_tdata[g*AXIS_W +: AXIS_W]),
            .i_gyro      (s_axis_tdata[(NUM_AX+g)*AXIS_W +: AXIS_W]),
            .i_accel_ofs (r_accel_ofs[g]),
            .i_ctl       (lane_ctl),
            .o_sq        (lane_sq[g]),
            .o_accel_out (item[g*OUT_W +: OUT_W]),
            .o_gyro_out  (item[(NUM_AX+g)*OUT_W +: OUT_W])
        );
    end

    imu_gbc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pop         (pop),
        .i_still_limit (r_still_limit),
        .i_sq          (lane_sq),
        .o_ctl         (lane_ctl),
        .o_push        (push),
        .o_ready       (s_axis_tready)
    );

    imu_gbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (q_data),
        .o_pop   (pop)
    );

    assign m_axis_tdata = {(OUT_TDATA_W-ITEM_W)'(0), q_data};

endmodule

`default_nettype wire

// ===== rtl/core/imu_gbc_chk.sv =====
// Port-level checker for imu_gyro_bias_calibrator, bound to the top level.
// Depends on imu_gbc_pkg.
`default_nettype none

module imu_gbc_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [imu_gbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [imu_gbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                                i_cfg_we,
    input wire logic [imu_gbc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input wire logic [imu_gbc_pkg::CFG_W-1:0]       i_cfg_data
);
    import imu_gbc_pkg::*;

    localparam int IN_CNT_W  = CNT_W + 1;
    localparam int FIRST_OUT = CAL_COUNT + 2;

    logic [IN_CNT_W-1:0] r_in_cnt;

    // saturating count of input transactions since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt <= '0;
        end else if (s_axis_tvalid && s_axis_tready
                     && (r_in_cnt != IN_CNT_W'(FIRST_OUT))) begin
            r_in_cnt <= r_in_cnt + 1'b1;
        end
    end

    a_rst_no_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_in_cnt == IN_CNT_W'(FIRST_OUT))
        else $error("result before calibration and swallowed sample");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata, i_cfg_we, i_cfg_idx, i_cfg_data};

endmodule

bind imu_gyro_bias_calibrator imu_gbc_chk u_imu_gbc_chk (.*);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for imu_gyro_bias_calibrator: feeds IMU samples on the stream input, tracks the
// calibration and correction in a scoreboard class, and checks every output transaction.
// Depends on imu_gbc_pkg and the imu_gyro_bias_calibrator RTL.

module tb;
    import imu_gbc_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int RUN_ITEMS    = 80;
    localparam int AXV_MAX      = 16777215;
    localparam int AXV_MIN      = -16777216;
    localparam int LIM_MAX      = 16777215;
    localparam longint SUM_HI   = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_LO   = -(longint'(1) << (SUM_W - 1));

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic signed [OUT_W-1:0]  t_out_axis;

    typedef struct {
        t_axis accel [NUM_AX];
        t_axis gyro  [NUM_AX];
    } t_imu_sample;

    typedef struct {
        t_out_axis accel [NUM_AX];
        t_out_axis gyro  [NUM_AX];
    } t_imu_result;

    typedef enum logic [1:0] {PH_CALIBRATE, PH_SWALLOW, PH_RUN} t_cal_phase;

    class calib_scoreboard;
        t_axis            accel_offset [NUM_AX];
        logic [LIM_W-1:0] still_limit;
        t_cal_phase       phase;
        int               still_count;
        longint           gyro_sum  [NUM_AX];
        longint           gyro_bias [NUM_AX];
        t_imu_result      corrected_q [$];
        int               errors;

        function new();
            foreach (accel_offset[i]) begin
                accel_offset[i] = '0;
                gyro_sum[i]     = 0;
                gyro_bias[i]    = 0;
            end
            still_limit = STILL_LIMIT_RST;
            phase       = PH_CALIBRATE;
            still_count = 0;
            errors      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_ACCEL_X:     accel_offset[0] = val;
                CFG_ACCEL_Y:     accel_offset[1] = val;
                CFG_ACCEL_Z:     accel_offset[2] = val;
                CFG_STILL_LIMIT: still_limit = val[LIM_W-1:0];
                default: begin
                end
            endcase
        endfunction

        // round half away from zero, then clamp to the bias range
        function longint round_bias(longint sum);
            longint mag;
            longint q;
            mag = (sum < 0) ? -sum : sum;
            q = (mag + CAL_COUNT / 2) / CAL_COUNT;
            if (sum < 0)
                q = -q;
            if (q > OFS_MAX)
                q = OFS_MAX;
            if (q < -OFS_NEG_MAG)
                q = -OFS_NEG_MAG;
            return q;
        endfunction

        function void take_sample(t_imu_sample s);
            longint      g [NUM_AX];
            longint      norm2;
            longint      lim;
            t_imu_result r;
            for (int i = 0; i < NUM_AX; i++)
                g[i] = s.gyro[i];
            case (phase)
                PH_CALIBRATE: begin
                    norm2 = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];
                    lim   = still_limit;
                    if (norm2 > lim * lim) begin
                        still_count = 0;
                        foreach (gyro_sum[i])
                            gyro_sum[i] = 0;
                    end else begin
                        for (int i = 0; i < NUM_AX; i++) begin
                            gyro_sum[i] += g[i];
                            if (gyro_sum[i] > SUM_HI)
                                gyro_sum[i] = SUM_HI;
                            else if (gyro_sum[i] < SUM_LO)
                                gyro_sum[i] = SUM_LO;
                        end
                        still_count++;
                        if (still_count == CAL_COUNT) begin
                            for (int i = 0; i < NUM_AX; i++)
                                gyro_bias[i] = round_bias(gyro_sum[i]);
                            phase = PH_SWALLOW;
                        end
                    end
                end
                PH_SWALLOW: phase = PH_RUN;
                default: begin
                    for (int i = 0; i < NUM_AX; i++) begin
                        r.accel[i] = t_out_axis'(longint'(s.accel[i])
                                                 - longint'(accel_offset[i]));
                        r.gyro[i]  = t_out_axis'(g[i] - gyro_bias[i]);
                    end
                    corrected_q.push_back(r);
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("ERROR @%0t: %s", $time, what);
        endtask

        task check_corrected(t_imu_result got);
            t_imu_result want;
            if (corrected_q.size() == 0) begin
                report("output transaction with no sample pending");
                return;
            end
            want = corrected_q.pop_front();
            for (int i = 0; i < NUM_AX; i++) begin
                if (got.accel[i] !== want.accel[i])
                    report($sformatf("accel_out[%0d]: got %0d, want %0d",
                                     i, got.accel[i], want.accel[i]));
                if (got.gyro[i] !== want.gyro[i])
                    report($sformatf("gyro_out[%0d]: got %0d, want %0d",
                                     i, got.gyro[i], want.gyro[i]));
            end
        endtask
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;

    int send_idle_pct = 30;
    int recv_idle_pct = 59;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    calib_scoreboard calib_sb;
    t_imu_result     seen;

    imu_gyro_bias_calibrator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("imu_gyro_bias_calibrator: mismatch");
            $finish;
        end
    end

    // output side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_served   <= hold_served + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            for (int i = 0; i < NUM_AX; i++) begin
                seen.accel[i] = m_axis_tdata[i * OUT_W +: OUT_W];
                seen.gyro[i]  = m_axis_tdata[(NUM_AX + i) * OUT_W +: OUT_W];
            end
            calib_sb.check_corrected(seen);
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int rand_axis();
        case ($urandom_range(15))
            0:       return AXV_MAX;
            1:       return AXV_MIN;
            2:       return 0;
            3:       return -1;
            default: return rand_between(AXV_MIN, AXV_MAX);
        endcase
    endfunction

    // called in step with the clock; returns once the sample has been accepted
    task automatic send_sample(input int ax, ay, az, gx, gy, gz);
        t_imu_sample           smp;
        logic [IN_TDATA_W-1:0] word;
        smp.accel[0] = t_axis'(ax);
        smp.accel[1] = t_axis'(ay);
        smp.accel[2] = t_axis'(az);
        smp.gyro[0]  = t_axis'(gx);
        smp.gyro[1]  = t_axis'(gy);
        smp.gyro[2]  = t_axis'(gz);
        word = '0;
        for (int i = 0; i < NUM_AX; i++) begin
            word[i * AXIS_W +: AXIS_W]            = smp.accel[i];
            word[(NUM_AX + i) * AXIS_W +: AXIS_W] = smp.gyro[i];
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        calib_sb.take_sample(smp);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (calib_sb.corrected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input int ofs_x, ofs_y, ofs_z, lim_word);
        logic [CFG_W-1:0]     vals [4];
        logic [CFG_IDX_W-1:0] idx  [4];
        vals[0] = CFG_W'(ofs_x);
        vals[1] = CFG_W'(ofs_y);
        vals[2] = CFG_W'(ofs_z);
        vals[3] = CFG_W'(lim_word);
        idx[0]  = CFG_ACCEL_X;
        idx[1]  = CFG_ACCEL_Y;
        idx[2]  = CFG_ACCEL_Z;
        idx[3]  = CFG_STILL_LIMIT;
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            calib_sb.write_register(idx[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int lim;
        int gx;
        int gy;
        int gz;
        int sum_z;
        calib_sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // threshold edges at the reset still limit
        send_sample(AXV_MAX, AXV_MAX, AXV_MAX, 32768, 0, 0);
        send_sample(AXV_MIN, AXV_MIN, AXV_MIN, 0, -32768, 0);
        send_sample(0, -1, AXV_MAX, 0, 0, -32768);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 18918, 18918, 18918);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 18919, 18919, 18918);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 32769, 0, 0);
        send_sample(rand_axis(), rand_axis(), rand_axis(), AXV_MAX, AXV_MIN, AXV_MAX);

        drain();
        apply_config(0, 0, 0, 0);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 0, 0, 0);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 0, 0, 1);
        send_sample(rand_axis(), rand_axis(), rand_axis(), -1, 0, 0);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 0, 0, 0);

        // bit 24 of the limit write is dropped
        drain();
        apply_config(AXV_MAX, AXV_MIN, AXV_MAX, 33554431);
        send_sample(rand_axis(), rand_axis(), rand_axis(), AXV_MAX, 0, 0);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 0, 0, AXV_MIN);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 0, AXV_MAX, 0);
        send_sample(rand_axis(), rand_axis(), rand_axis(), 0, -AXV_MAX, 0);

        // still runs cut short by a moving sample
        drain();
        lim = rand_between(1000, 1000000);
        apply_config(rand_axis(), rand_axis(), rand_axis(), lim);
        repeat (3) begin
            repeat (rand_between(10, 40))
                send_sample(rand_axis(), rand_axis(), rand_axis(), rand_between(-lim / 2, lim / 2),
                            rand_between(-lim / 2, lim / 2), rand_between(-lim / 2, lim / 2));
            send_sample(rand_axis(), rand_axis(), rand_axis(), rand_between(-lim / 2, lim / 2),
                        lim + rand_between(1, 1000), 0);
        end

        // full calibration: x sum saturates then comes back into range, y bias clamps low,
        // z ends on an exact half below zero
        drain();
        apply_config(rand_axis(), rand_axis(), rand_axis(), LIM_MAX);
        sum_z = 0;
        for (int n = 0; n < CAL_COUNT; n++) begin
            if (n < 10) begin
                gx = rand_between(10500000, 11000000);
                gy = -rand_between(10500000, 11000000);
            end else begin
                gx = rand_between(-67900, -67500);
                gy = -rand_between(0, 1000);
            end
            gz = rand_between(-2000, 2000);
            if (n == CAL_COUNT - 1)
                gz = -sum_z - 500500;
            sum_z += gz;
            send_sample(rand_axis(), rand_axis(), rand_axis(), gx, gy, gz);
        end

        // first sample of the first run phase is the swallowed one
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            case (ph)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 59;
                    apply_config(AXV_MAX, AXV_MAX, AXV_MAX, 0);
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 30;
                    apply_config(AXV_MIN, AXV_MIN, AXV_MIN, rand_between(0, LIM_MAX));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    apply_config(rand_axis(), rand_axis(), rand_axis(), LIM_MAX);
                    hold_requests <= hold_requests + 1;
                end
            endcase
            for (int n = 0; n < RUN_ITEMS; n++)
                send_sample(rand_axis(), rand_axis(), rand_axis(),
                            rand_axis(), rand_axis(), rand_axis());
        end

        drain();
        if (calib_sb.errors == 0)
            $display("imu_gyro_bias_calibrator: match");
        else
            $display("imu_gyro_bias_calibrator: mismatch");
        $finish;
    end

endmodule
